[hdl/utf8pv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8pv_pkg
// Shared types, constants and helpers for the UTF-8 path validator.
// ----------------------------------------------------------------------------
package utf8pv_pkg;

  localparam int unsigned LenW  = 16;  // max_length register
  localparam int unsigned CntW  = 17;  // byte counter, holds max_length + 1
  localparam int unsigned CodeW = 21;  // decoded code point

  // lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [1:0] CONT_TAG = 2'b10;

  localparam logic [CodeW-1:0] MIN_CLS1 = 21'h00080;
  localparam logic [CodeW-1:0] MIN_CLS2 = 21'h00800;
  localparam logic [CodeW-1:0] MIN_CLS3 = 21'h10000;
  localparam logic [CodeW-1:0] CP_MAX   = 21'h10FFFF;
  localparam logic [CodeW-1:0] SURR_LO  = 21'h0D800;
  localparam logic [CodeW-1:0] SURR_HI  = 21'h0DFFF;

  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  // sequence class codes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_TWO  = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_FOUR = 2'd3;

  // per-string decode state
  typedef struct packed {
    logic [1:0]       pending;  // continuation bytes still expected
    logic [CodeW-1:0] partial;  // value decoded so far
    logic [1:0]       cls;      // class of the open sequence
    logic [CntW-1:0]  count;    // bytes seen, saturating
    logic             err;      // a rule was broken
  } str_state_t;

  function automatic logic [CodeW-1:0] class_min(input logic [1:0] cls);
    logic [CodeW-1:0] m;
    case (cls)
      CLS_TWO:   m = MIN_CLS1;
      CLS_THREE: m = MIN_CLS2;
      default:   m = MIN_CLS3;
    endcase
    return m;
  endfunction

endpackage

[hdl/utf8pv_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8pv_step
// One-word update of the decode state, plus the verdict for an end marker.
// ----------------------------------------------------------------------------
module utf8pv_step (
  input  utf8pv_pkg::str_state_t       st,
  input  logic [7:0]                   data_byte,
  input  logic                         end_marker,
  input  logic [utf8pv_pkg::LenW-1:0]  max_length,
  output utf8pv_pkg::str_state_t       st_next,
  output logic                         is_valid
);

  logic [utf8pv_pkg::CntW-1:0]  cnt_lim;
  logic [utf8pv_pkg::CntW-1:0]  max_ext;
  logic [utf8pv_pkg::CodeW-1:0] pv_shift;
  logic                         bad_cp;
  utf8pv_pkg::str_state_t       st_byte;

  assign max_ext  = {1'b0, max_length};
  assign cnt_lim  = max_ext + utf8pv_pkg::CntW'(1);
  assign pv_shift = {st.partial[utf8pv_pkg::CodeW-7:0], data_byte[5:0]};

  // range checks on a completed sequence
  assign bad_cp = (pv_shift < utf8pv_pkg::class_min(st.cls)) ||
                  (pv_shift > utf8pv_pkg::CP_MAX) ||
                  ((pv_shift >= utf8pv_pkg::SURR_LO) && (pv_shift <= utf8pv_pkg::SURR_HI));

  always_comb begin
    st_byte = st;
    if (st.count < cnt_lim) begin
      st_byte.count = st.count + utf8pv_pkg::CntW'(1);
    end
    if (!st.err) begin
      if (st.pending != 2'd0) begin
        if (data_byte[7:6] != utf8pv_pkg::CONT_TAG) begin
          st_byte.err = 1'b1;
        end else begin
          st_byte.partial = pv_shift;
          st_byte.pending = st.pending - 2'd1;
          if (st.pending == 2'd1) begin
            st_byte.err     = bad_cp;
            st_byte.partial = '0;
            st_byte.cls     = utf8pv_pkg::CLS_NONE;
          end
        end
      end else if (data_byte[7]) begin
        if (data_byte inside {[utf8pv_pkg::LEAD2_LO:utf8pv_pkg::LEAD2_HI]}) begin
          st_byte.cls     = utf8pv_pkg::CLS_TWO;
          st_byte.pending = utf8pv_pkg::CLS_TWO;
          st_byte.partial = utf8pv_pkg::CodeW'(data_byte[4:0]);
        end else if (data_byte inside {[utf8pv_pkg::LEAD3_LO:utf8pv_pkg::LEAD3_HI]}) begin
          st_byte.cls     = utf8pv_pkg::CLS_THREE;
          st_byte.pending = utf8pv_pkg::CLS_THREE;
          st_byte.partial = utf8pv_pkg::CodeW'(data_byte[3:0]);
        end else if (data_byte inside {[utf8pv_pkg::LEAD4_LO:utf8pv_pkg::LEAD4_HI]}) begin
          st_byte.cls     = utf8pv_pkg::CLS_FOUR;
          st_byte.pending = utf8pv_pkg::CLS_FOUR;
          st_byte.partial = utf8pv_pkg::CodeW'(data_byte[2:0]);
        end else begin
          st_byte.err = 1'b1;
        end
      end
    end
  end

  assign is_valid = !st.err && (st.pending == 2'd0) &&
                    (st.count != '0) && (st.count <= max_ext);

  // an end marker clears the string state
  assign st_next = end_marker ? utf8pv_pkg::str_state_t'('0) : st_byte;

endmodule

[hdl/utf8_path_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_path_validator
// Strict UTF-8 checker for byte strings with a length limit.
// ----------------------------------------------------------------------------
// Feed one byte per word on the slave stream; a word with tlast set carries
// no byte and closes the string, and one verdict word comes out for it
// (tdata bit 0 = 1 when the string is non-empty, no longer than max_length,
// properly terminated and strict UTF-8: no overlongs, surrogates or values
// above 10FFFF). Throughput is one word per clock unless an end word stalls.
// Each word passes through the input register and is then folded into the
// string state; a verdict enters the output register as its end word
// leaves the input register. The only stall is an end word waiting there
// while the previous verdict is still unread; byte words keep flowing.
// max_length (reset 4096) is written through the cfg channel, which is
// always ready; write it between strings.
// ----------------------------------------------------------------------------
module utf8_path_validator (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [utf8pv_pkg::LenW-1:0]  cfg_data,    // [15:0] max_length
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tlast,  // end_marker
  // verdict stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata   // [0] is_valid, [7:1] zero
);

  // config register
  logic [utf8pv_pkg::LenW-1:0] max_length;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // string state
  utf8pv_pkg::str_state_t st;
  utf8pv_pkg::str_state_t st_next;
  logic                   verdict;

  // output register
  logic out_valid;
  logic out_ok;

  logic advance;

  assign cfg_ready = 1'b1;

  // byte words never wait; an end word waits for a free output register
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  utf8pv_step u_step (
    .st         (st),
    .data_byte  (in_byte),
    .end_marker (in_last),
    .max_length (max_length),
    .st_next    (st_next),
    .is_valid   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= utf8pv_pkg::MAX_LEN_RESET;
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      st         <= '0;
    end else begin
      if (cfg_valid) begin
        max_length <= cfg_data;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        st <= st_next;
      end
      if (advance && in_last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance && in_last) begin
      out_ok <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_ok};

`ifndef NO_ASSERTIONS
  // an end word must not overwrite an unread verdict
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_last && out_valid && !m_axis_tready) |-> !advance)
    else $error("verdict overrun");

  // string state is clear right after an end word
  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (st.count == '0 && st.pending == 2'd0 && !st.err))
    else $error("state not cleared after end word");

  // pending continuations never exceed what the open class asked for
  a_pending_cls: assert property (@(posedge clk) disable iff (rst)
    st.pending <= st.cls)
    else $error("pending count above sequence class");
`endif

endmodule

[tb/tb_utf8_path_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_path_validator
// Self-checking stream bench for the strict UTF-8 path validator.
// ----------------------------------------------------------------------------
// A software copy of the decoder follows every word that the validator
// accepts. On each end word it queues the verdict it expects, and every
// verdict word that comes out is compared with the oldest one in the queue.
// The run starts with a short directed part: the empty string, the zero
// byte, invalid, stray and interrupted bytes, the largest code point, a
// string that ends inside a sequence, a limit of zero, and a limit that
// changes while a string is open. After that come random phases, one for
// each max_length setting. Most strings are well-formed UTF-8 with random
// content and, for limits up to 40, lengths close to the limit. The rest
// hold overlongs, surrogates, values above 10FFFF, bad leads, stray or
// interrupted bytes, cut-off sequences or raw random bytes. Both sides
// idle at random; one phase runs with no idling at all. In one phase the
// verdict side holds off for a long time, so end words pile up behind it.
// ----------------------------------------------------------------------------
module tb_utf8_path_validator;
  import utf8pv_pkg::*;

  typedef enum int {CH_ASCII, CH_TWO, CH_THREE, CH_FOUR} char_kind_e;
  typedef enum int {
    BAD_OVER2, BAD_OVER3, BAD_OVER4, BAD_SURR,
    BAD_HIGH, BAD_LEAD, BAD_STRAY, BAD_BREAK
  } bad_kind_e;

  // Decoder copy plus the queue of verdicts still owed by the block.
  class verdict_board;
    logic [LenW-1:0]  max_len;
    logic [1:0]       pending;   // continuations still expected
    logic [CodeW-1:0] partial;   // code point so far
    logic [1:0]       cls;
    logic [CntW-1:0]  count;     // saturates at max_len + 1
    logic             err;
    bit               due[$];    // expected verdicts, oldest first
    int unsigned      fails;
    int unsigned      checked;
    int unsigned      good;

    function new();
      max_len = MAX_LEN_RESET;
      restart();
      fails = 0;
      checked = 0;
      good = 0;
    endfunction

    function void restart();
      pending = 2'd0;
      partial = '0;
      cls = CLS_NONE;
      count = '0;
      err = 1'b0;
    endfunction

    function void set_limit(logic [LenW-1:0] v);
      max_len = v;
    endfunction

    // Called for every word taken on the input stream.
    function void note_word(logic [7:0] b, logic last);
      logic [CodeW-1:0] floor_cp;
      if (last) begin
        due.push_back(!err && pending == 2'd0 && count != '0 &&
                      count <= {1'b0, max_len});
        restart();
        return;
      end
      if (count < {1'b0, max_len} + 17'd1) count = count + 17'd1;
      if (err) return;    // counted, no longer decoded
      if (pending != 2'd0) begin
        if (b[7:6] != CONT_TAG) begin
          err = 1'b1;
          return;
        end
        partial = {partial[CodeW-7:0], b[5:0]};
        pending = pending - 2'd1;
        if (pending == 2'd0) begin
          case (cls)
            CLS_TWO:   floor_cp = MIN_CLS1;
            CLS_THREE: floor_cp = MIN_CLS2;
            default:   floor_cp = MIN_CLS3;
          endcase
          if (partial < floor_cp || partial > CP_MAX ||
              (partial >= SURR_LO && partial <= SURR_HI))
            err = 1'b1;
          partial = '0;
          cls = CLS_NONE;
        end
        return;
      end
      if (!b[7]) return;
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        cls = CLS_TWO;
        partial = {16'd0, b[4:0]};
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        cls = CLS_THREE;
        partial = {17'd0, b[3:0]};
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        cls = CLS_FOUR;
        partial = {18'd0, b[2:0]};
      end else begin
        err = 1'b1;
        return;
      end
      pending = cls;    // class code equals the continuation count
    endfunction

    function void check_verdict(logic [7:0] word);
      bit want;
      if (due.size() == 0) begin
        $error("verdict word %02h with no end word outstanding", word);
        fails++;
        return;
      end
      want = due.pop_front();
      checked++;
      if (want) good++;
      if (word[0] !== want) begin
        $error("is_valid mismatch: expected %0d, actual %0d", want, word[0]);
        fails++;
      end
      if (word[7:1] !== 7'd0) begin
        $error("tdata pad mismatch: expected 0, actual %0h", word[7:1]);
        fails++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [LenW-1:0] cfg_data = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = 8'd0;   // [7:0] data_byte
  logic            s_axis_tlast = 1'b0;   // end_marker
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;          // [0] is_valid, [7:1] zero

  verdict_board judge = new();

  bit          idle_en = 1'b1;      // random gaps on both sides
  bit          hold_req = 1'b0;     // asks the verdict side for a long hold-off
  int unsigned stall_left = 0;
  int unsigned words_sent = 0;
  logic [7:0]  str_bytes[$];        // string being built for the next send

  always #10 clk = ~clk;

  utf8_path_validator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Run limit. The slowest correct run stays well below a fifth of it.
  initial begin
    #10_000_000;
    $display("FAIL utf8_path_validator");
    $finish;
  end

  // Verdict side. It checks each word it takes. When asked, it holds off for
  // a long time. Otherwise it idles at random.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) judge.check_verdict(m_axis_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 26);
      end
    end
  end

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // One well-formed character. Now and then it sits on the edge of its class.
  function automatic void add_char(input char_kind_e k);
    logic [CodeW-1:0] cp;
    bit at_bound;
    at_bound = ($urandom_range(0, 7) == 0);
    case (k)
      CH_ASCII: begin
        str_bytes.push_back(8'($urandom_range(0, 127)));
      end
      CH_TWO: begin
        cp = 21'($urandom_range('h80, 'h7FF));
        if (at_bound) cp = $urandom_range(0, 1) ? 21'h80 : 21'h7FF;
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      CH_THREE: begin
        do cp = 21'($urandom_range('h800, 'hFFFF));
        while (cp >= SURR_LO && cp <= SURR_HI);
        if (at_bound) begin
          case ($urandom_range(0, 3))
            0: cp = MIN_CLS2;
            1: cp = SURR_LO - 21'd1;
            2: cp = SURR_HI + 21'd1;
            default: cp = 21'hFFFF;
          endcase
        end
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        cp = 21'($urandom_range('h10000, 'h10FFFF));
        if (at_bound) cp = $urandom_range(0, 1) ? MIN_CLS3 : CP_MAX;
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // One broken character. It poisons the rest of the string.
  function automatic void add_bad(input bad_kind_e k);
    logic [7:0] b;
    case (k)
      BAD_OVER2: begin
        str_bytes.push_back(8'($urandom_range('hC0, 'hC1)));
        str_bytes.push_back(cont_byte());
      end
      BAD_OVER3: begin
        str_bytes.push_back(LEAD3_LO);
        str_bytes.push_back(8'($urandom_range('h80, 'h9F)));
        str_bytes.push_back(cont_byte());
      end
      BAD_OVER4: begin
        str_bytes.push_back(LEAD4_LO);
        str_bytes.push_back(8'($urandom_range('h80, 'h8F)));
        str_bytes.push_back(cont_byte());
        str_bytes.push_back(cont_byte());
      end
      BAD_SURR: begin
        str_bytes.push_back(8'hED);
        str_bytes.push_back(8'($urandom_range('hA0, 'hBF)));
        str_bytes.push_back(cont_byte());
      end
      BAD_HIGH: begin
        str_bytes.push_back(LEAD4_HI);
        str_bytes.push_back(8'($urandom_range('h90, 'hBF)));
        str_bytes.push_back(cont_byte());
        str_bytes.push_back(cont_byte());
      end
      BAD_LEAD: begin
        str_bytes.push_back(8'($urandom_range('hF5, 'hFF)));
        str_bytes.push_back(cont_byte());
      end
      BAD_STRAY: begin
        str_bytes.push_back(cont_byte());
      end
      default: begin
        // lead, then anything but a continuation
        str_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD4_HI)));
        b = 8'($urandom_range(0, 191));
        if (b >= 8'h80) b = b + 8'h40;
        str_bytes.push_back(b);
      end
    endcase
  endfunction

  // Lead byte with too few continuations: the string ends inside it.
  function automatic void add_cut();
    int unsigned need;
    need = $urandom_range(1, 3);
    case (need)
      1: str_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
      2: str_bytes.push_back(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
      default: str_bytes.push_back(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
    endcase
    repeat ($urandom_range(0, need - 1)) str_bytes.push_back(cont_byte());
  endfunction

  // Random string. Its length runs around the limit when the limit is small.
  task automatic build_string(input int unsigned lim);
    int unsigned target;
    int unsigned mode;
    int unsigned bad_at;
    bit bad_done;
    target = (lim <= 40) ? $urandom_range(0, lim + 3) : $urandom_range(0, 14);
    mode = $urandom_range(0, 99);
    bad_at = $urandom_range(0, target);
    bad_done = 1'b0;
    if (mode < 6) begin
      repeat (target) str_bytes.push_back(8'($urandom));
    end else begin
      while (str_bytes.size() < target) begin
        if (mode >= 70 && mode < 88 && !bad_done && str_bytes.size() >= bad_at) begin
          add_bad(bad_kind_e'($urandom_range(0, 7)));
          bad_done = 1'b1;
        end else begin
          add_char(char_kind_e'($urandom_range(0, 3)));
        end
      end
      if (mode >= 88) add_cut();
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic last);
    while (idle_en && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    judge.note_word(b, last);
    words_sent++;
  endtask

  // Sends the built string. The end word carries a random, ignored byte.
  task automatic send_string(input bit with_end);
    foreach (str_bytes[i]) send_word(str_bytes[i], 1'b0);
    if (with_end) send_word(8'($urandom), 1'b1);
    str_bytes.delete();
  endtask

  // Waits until every verdict is in and the last bytes are folded in.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (judge.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LenW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    judge.set_limit(v);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [LenW-1:0] limits[7];
    int unsigned quota;
    bit paused;

    paused = 1'b0;
    limits = '{16'd1, 16'd3, 16'd4096, 16'd17, 16'hFFFF,
               16'($urandom_range(2, 40)), 16'($urandom_range(1, 65535))};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part, reset limit of 4096 ---
    send_word(8'hA5, 1'b1);                                // empty string
    str_bytes = '{8'h00};                    send_string(1'b1);  // zero byte
    str_bytes = '{8'hFF, 8'h41};             send_string(1'b1);  // bad byte, tail ignored
    str_bytes = '{8'h80};                    send_string(1'b1);  // stray continuation
    str_bytes = '{8'hC2, 8'h41};             send_string(1'b1);  // interrupted sequence
    str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_string(1'b1);  // 10FFFF, accepted
    str_bytes = '{8'hE0};                    send_string(1'b1);  // ends inside sequence

    // limit zero: any non-empty string is too long
    settle();
    write_limit(16'd0);
    str_bytes = '{8'h41};                    send_string(1'b1);

    // Limit raised while a string is open. The count stopped at 3 and now
    // passes against 4.
    settle();
    write_limit(16'd2);
    str_bytes = '{8'h41, 8'h42, 8'h43};      send_string(1'b0);
    settle();
    write_limit(16'd4);
    send_word(8'h00, 1'b1);
    str_bytes = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45}; send_string(1'b1);  // too long

    // --- random phases, one per limit ---
    for (int p = 0; p < 7; p++) begin
      settle();
      write_limit(limits[p]);
      idle_en = (p != 2);                 // phase 2 runs flat out
      if (p == 3) begin
        // End words stall behind unread verdicts while the sender keeps offering.
        hold_req = 1'b1;
        repeat (40) begin
          build_string(2);
          send_string(1'b1);
        end
      end
      quota = words_sent + 180;
      while (words_sent < quota) begin
        build_string(limits[p]);
        send_string(1'b1);
        if (p == 1 && !paused && words_sent + 100 >= quota) begin
          settle();                       // sender quiet until all verdicts are back
          paused = 1'b1;
        end
      end
      // sometimes leave a string open across the next limit change
      if ($urandom_range(0, 1)) begin
        build_string(limits[p]);
        send_string(1'b0);
      end
    end

    // close any open string and drain
    send_word(8'h00, 1'b1);
    settle();
    repeat (10) @(posedge clk);

    if (judge.due.size() != 0) begin
      $error("%0d verdicts never arrived", judge.due.size());
      judge.fails++;
    end
    $display("Covered %0d words and %0d verdicts (%0d valid) over limits 0, 1 and 65535",
             words_sent, judge.checked, judge.good);
    $display("and several in between, plus a long hold-off and a sender pause.");
    if (judge.fails == 0) begin
      $display("PASS utf8_path_validator");
    end else begin
      $display("FAIL utf8_path_validator");
    end
    $finish;
  end

endmodule
